>>> sv/pwbe_pkg.sv
package pwbe_pkg;

  localparam int unsigned ByteBits      = 8;
  localparam int unsigned WidthBits     = 16;
  localparam int unsigned PreamblePairs = 9;
  localparam int unsigned CfgIdxBits    = 2;

  // The pair counter covers both the preamble pairs and the data bits.
  localparam int unsigned CntMax  = (PreamblePairs > ByteBits) ? PreamblePairs : ByteBits;
  localparam int unsigned CntBits = $clog2(CntMax);

  localparam logic [WidthBits-1:0] LongWidthReset  = 16'd16799;
  localparam logic [WidthBits-1:0] ShortWidthReset = 16'd8399;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LONG_WIDTH  = 2'd0,
    CFG_SHORT_WIDTH = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PRE_LONG,
    SEQ_PRE_PAIRS,
    SEQ_DATA,
    SEQ_PARITY
  } seq_state_e;

  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic                frame_start;
  } in_item_t;

  typedef struct packed {
    logic [WidthBits-1:0] half_period;
    logic                 run_last;
  } out_item_t;

  // One symbol as the sequencer sees it: its kind and the end-of-run mark.
  typedef struct packed {
    logic is_long;
    logic last;
  } sym_t;

  typedef struct packed {
    logic [WidthBits-1:0] long_width;
    logic [WidthBits-1:0] short_width;
  } widths_t;

endpackage

>>> sv/pwbe_cfg_regs.sv
module pwbe_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pwbe_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [pwbe_pkg::WidthBits-1:0]    cfg_data_i,
  output pwbe_pkg::widths_t                 widths_o
);

  pwbe_pkg::widths_t widths_d, widths_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    widths_d = widths_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pwbe_pkg::CFG_LONG_WIDTH:  widths_d.long_width  = cfg_data_i;
        pwbe_pkg::CFG_SHORT_WIDTH: widths_d.short_width = cfg_data_i;
        default: ;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widths_q.long_width  <= pwbe_pkg::LongWidthReset;
      widths_q.short_width <= pwbe_pkg::ShortWidthReset;
    end else begin
      widths_q <= widths_d;
    end
  end

  assign widths_o = widths_q;

endmodule

>>> sv/pwbe_seq.sv
module pwbe_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pwbe_pkg::in_item_t in_data_i,
  output logic               sym_valid_o,
  input  logic               sym_ready_i,
  output pwbe_pkg::sym_t     sym_o
);

  localparam int unsigned CntBits = pwbe_pkg::CntBits;
  localparam logic [CntBits-1:0] PreLastCnt  = CntBits'(pwbe_pkg::PreamblePairs - 1);
  localparam logic [CntBits-1:0] DataLastCnt = CntBits'(pwbe_pkg::ByteBits - 1);

  pwbe_pkg::seq_state_e state_d, state_q;
  logic [CntBits-1:0]            cnt_d, cnt_q;
  logic                          half_d, half_q;
  logic                          parity_d, parity_q;
  logic [pwbe_pkg::ByteBits-1:0] shift_d, shift_q;
  logic                          adv;

  assign adv = sym_valid_o && sym_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    half_d      = half_q;
    parity_d    = parity_q;
    shift_d     = shift_q;
    in_ready_o  = 1'b0;
    sym_valid_o = 1'b0;
    sym_o       = '0;

    unique case (state_q)
      pwbe_pkg::SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          shift_d  = in_data_i.data_byte;
          parity_d = 1'b0;
          half_d   = 1'b0;
          cnt_d    = '0;
          state_d  = in_data_i.frame_start ? pwbe_pkg::SEQ_PRE_LONG : pwbe_pkg::SEQ_DATA;
        end
      end
      pwbe_pkg::SEQ_PRE_LONG: begin
        sym_valid_o   = 1'b1;
        sym_o.is_long = 1'b1;
        if (adv) begin
          state_d = pwbe_pkg::SEQ_PRE_PAIRS;
        end
      end
      pwbe_pkg::SEQ_PRE_PAIRS: begin
        sym_valid_o = 1'b1;
        if (adv) begin
          half_d = ~half_q;
          if (half_q) begin
            if (cnt_q == PreLastCnt) begin
              cnt_d   = '0;
              state_d = pwbe_pkg::SEQ_DATA;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
      end
      pwbe_pkg::SEQ_DATA: begin
        sym_valid_o   = 1'b1;
        sym_o.is_long = shift_q[0];
        if (adv) begin
          half_d = ~half_q;
          if (half_q) begin
            // The bit has gone out twice: fold it into the parity and move on.
            parity_d = parity_q ^ shift_q[0];
            shift_d  = {1'b0, shift_q[pwbe_pkg::ByteBits-1:1]};
            if (cnt_q == DataLastCnt) begin
              cnt_d   = '0;
              state_d = pwbe_pkg::SEQ_PARITY;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
      end
      pwbe_pkg::SEQ_PARITY: begin
        sym_valid_o   = 1'b1;
        sym_o.is_long = parity_q;
        sym_o.last    = half_q;
        if (adv) begin
          half_d = ~half_q;
          if (half_q) begin
            state_d = pwbe_pkg::SEQ_IDLE;
          end
        end
      end
      default: begin
        state_d = pwbe_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwbe_pkg::SEQ_IDLE;
      cnt_q   <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    parity_q <= parity_d;
  end

endmodule

>>> sv/pwbe_out_reg.sv
module pwbe_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sym_valid_i,
  output logic                sym_ready_o,
  input  pwbe_pkg::sym_t      sym_i,
  input  pwbe_pkg::widths_t   widths_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pwbe_pkg::out_item_t out_data_o
);

  logic                valid_d, valid_q;
  pwbe_pkg::out_item_t data_d, data_q;
  logic                load;

  // The register takes a new symbol whenever it is empty or being drained.
  assign sym_ready_o = !valid_q || out_ready_i;
  assign load        = sym_valid_i && sym_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d            = 1'b1;
      data_d.half_period = sym_i.is_long ? widths_i.long_width : widths_i.short_width;
      data_d.run_last    = sym_i.last;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> sv/pulse_width_bit_encoder_parity_top.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i   (data_byte, frame_start)
// out       output     out_valid_o / out_ready_i  out_data_o  (half_period, run_last)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item yields 18 symbols, or 37 when it starts a frame, and the sequencer sends one
// symbol per cycle while the output is not stalled; the bit sequencer handles one item
// at a time and takes no new item until the last symbol of the current one is sent.
// Reset returns both widths to their defaults and empties the sequencer and output register.
// A stall on the output holds the sequencer on its current symbol; nothing is dropped.
module pulse_width_bit_encoder_parity_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pwbe_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pwbe_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pwbe_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [pwbe_pkg::WidthBits-1:0]    cfg_data_i
);

  // Current long and short half-period counts.
  pwbe_pkg::widths_t widths;

  // Symbol stream from the sequencer to the output register.
  logic           sym_valid;
  logic           sym_ready;
  pwbe_pkg::sym_t sym;

  pwbe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .widths_o    (widths)
  );

  // The sequencer shifts the byte out one bit per symbol pair, LSB first, and
  // accumulates the parity as it goes. The preamble comes first when the item
  // starts a frame, and the parity pair closes every run with the last mark
  // on its second symbol.
  pwbe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .sym_valid_o (sym_valid),
    .sym_ready_i (sym_ready),
    .sym_o       (sym)
  );

  // The output register turns the symbol kind into a timer count and holds it while the
  // consumer stalls. The user must change widths only while the block is idle; the block
  // itself does not enforce it. Then selecting them here gives the same counts as upstream.
  pwbe_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_valid_i (sym_valid),
    .sym_ready_o (sym_ready),
    .sym_i       (sym),
    .widths_i    (widths),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/sv/tb_pulse_width_bit_encoder_parity_top.sv
module tb_pulse_width_bit_encoder_parity_top;
  timeunit 1ns;
  timeprecision 1ps;

  // A driver process feeds command bytes from a queue into the input channel and a
  // monitor process drains the symbol channel. Every byte that the encoder accepts is
  // expanded here into the symbols it must produce, using a local copy of the two
  // width registers, and each symbol that comes out is checked against the oldest one
  // still outstanding. Register writes happen only while the encoder is drained.

  // Register indexes that do not select a register; writes to them must be dropped.
  localparam logic [pwbe_pkg::CfgIdxBits-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [pwbe_pkg::CfgIdxBits-1:0] CfgIdxSpareHi = 2'd3;

  localparam logic [pwbe_pkg::WidthBits-1:0] WidthMax = '1;
  localparam logic [pwbe_pkg::WidthBits-1:0] WidthMin = '0;

  // Cycles to wait once nothing is outstanding.
  localparam int unsigned DrainCycles = 60;
  // Length of the long receiver hold-off that forces the input side to stall.
  localparam int unsigned LongHold    = 300;
  localparam int unsigned ReportLimit = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            in_valid  = 1'b0;
  logic                            in_ready_o;
  pwbe_pkg::in_item_t              in_data   = '0;
  logic                            out_valid_o;
  logic                            out_ready = 1'b0;
  pwbe_pkg::out_item_t             out_data_o;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready_o;
  logic [pwbe_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [pwbe_pkg::WidthBits-1:0]  cfg_data  = '0;

  pulse_width_bit_encoder_parity_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Bytes waiting to be offered, and symbols that accepted bytes still owe us.
  pwbe_pkg::in_item_t  byte_backlog[$];
  pwbe_pkg::out_item_t owed_symbols[$];

  // Our own view of the width registers, updated on every accepted write.
  logic [pwbe_pkg::WidthBits-1:0] long_w  = pwbe_pkg::LongWidthReset;
  logic [pwbe_pkg::WidthBits-1:0] short_w = pwbe_pkg::ShortWidthReset;

  // When set, neither side inserts gaps, so long back-to-back stretches occur.
  logic        steady_flow = 1'b0;
  logic        hold_start  = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned mismatch_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, sometimes a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A pair is two equal half-periods; only the second may close the run.
  function automatic void owe_pair(input logic is_one, input logic closes_run);
    logic [pwbe_pkg::WidthBits-1:0] w;
    w = is_one ? long_w : short_w;
    owed_symbols.push_back('{half_period: w, run_last: 1'b0});
    owed_symbols.push_back('{half_period: w, run_last: closes_run});
  endfunction

  // Expands one accepted byte into its symbols: optional preamble, the eight data
  // bits LSB first, then the pair that makes the number of ones even.
  function automatic void encode_byte(input pwbe_pkg::in_item_t it);
    logic odd_ones;
    odd_ones = 1'b0;
    if (it.frame_start) begin
      owed_symbols.push_back('{half_period: long_w, run_last: 1'b0});
      for (int p = 0; p < pwbe_pkg::PreamblePairs; p++) owe_pair(1'b0, 1'b0);
    end
    for (int b = 0; b < pwbe_pkg::ByteBits; b++) begin
      owe_pair(it.data_byte[b], 1'b0);
      odd_ones ^= it.data_byte[b];
    end
    owe_pair(odd_ones, 1'b1);
  endfunction

  // Driver: the payload only changes once the previous byte has been taken, and
  // the gap before the next byte is drawn when a byte is put on the bus.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) encode_byte(in_data);
      if (!in_valid || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog.pop_front();
          send_gap <= steady_flow ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Counts down the long hold-off on the symbol side once it has been requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= LongHold;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every symbol taken and decides the ready for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (owed_symbols.size() == 0) begin
          if (mismatch_count < ReportLimit)
            $display("%0t: symbol %0d/%0b with no byte pending", $realtime,
                     out_data_o.half_period, out_data_o.run_last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          pwbe_pkg::out_item_t want;
          want = owed_symbols.pop_front();
          if (out_data_o.half_period !== want.half_period ||
              out_data_o.run_last !== want.run_last) begin
            if (mismatch_count < ReportLimit)
              $display("%0t: half_period exp %0d got %0d, run_last exp %0b got %0b",
                       $realtime, want.half_period, out_data_o.half_period,
                       want.run_last, out_data_o.run_last);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (steady_flow || $urandom_range(0, 9) < 7) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  task automatic queue_byte(input logic [pwbe_pkg::ByteBits-1:0] b,
                            input logic starts_frame);
    byte_backlog.push_back('{data_byte: b, frame_start: starts_frame});
  endtask

  // Random traffic shaped as frames: a byte with the frame flag followed by a few
  // plain bytes, with the odd stray frame flag thrown in as noise.
  task automatic queue_random_frames(input int unsigned n);
    int unsigned left_in_frame;
    left_in_frame = 0;
    repeat (n) begin
      if (left_in_frame == 0) begin
        queue_byte(pwbe_pkg::ByteBits'($urandom_range(0, 255)), 1'b1);
        left_in_frame = $urandom_range(1, 6);
      end else begin
        queue_byte(pwbe_pkg::ByteBits'($urandom_range(0, 255)),
                   $urandom_range(0, 9) == 0);
        left_in_frame--;
      end
    end
  endtask

  // Holds a write on the channel until it is taken. Valid is left high so that
  // back-to-back writes need no second assignment in one step.
  task automatic write_reg(input logic [pwbe_pkg::CfgIdxBits-1:0] idx,
                           input logic [pwbe_pkg::WidthBits-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == pwbe_pkg::CFG_LONG_WIDTH) long_w = v;
    else if (idx == pwbe_pkg::CFG_SHORT_WIDTH) short_w = v;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every byte has been taken and every owed symbol has come out.
  task automatic drain();
    while (byte_backlog.size() != 0 || in_valid || owed_symbols.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [pwbe_pkg::WidthBits-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return WidthMin;
    if (r == 1) return WidthMax;
    return pwbe_pkg::WidthBits'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset widths: all-zero and all-one bytes, single set bits at both ends,
    // odd and even counts of ones, frames started and continued.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h55, 1'b1);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    drain();

    // Extreme widths, a zero short width among them, plus writes to unused indexes
    // that must leave both registers alone. No idling in this phase.
    steady_flow <= 1'b1;
    write_reg(pwbe_pkg::CFG_LONG_WIDTH, WidthMax);
    write_reg(pwbe_pkg::CFG_SHORT_WIDTH, WidthMin);
    write_reg(CfgIdxSpareLo, 16'h1234);
    write_reg(CfgIdxSpareHi, 16'hEDCB);
    end_writes();
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h01, 1'b1);
    drain();

    // Swapped extremes. The sender keeps offering bytes while the receiver holds
    // off for a long stretch, so the encoder backs up and stalls its input.
    write_reg(pwbe_pkg::CFG_LONG_WIDTH, WidthMin);
    write_reg(pwbe_pkg::CFG_SHORT_WIDTH, WidthMax);
    end_writes();
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_random_frames(10);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    drain();
    steady_flow <= 1'b0;

    // Random widths and random frames; one phase runs without idling.
    for (int ph = 0; ph < 4; ph++) begin
      if ($urandom_range(0, 1)) write_reg(pwbe_pkg::CFG_LONG_WIDTH, pick_width());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CfgIdxSpareLo : CfgIdxSpareHi,
                  pwbe_pkg::WidthBits'($urandom_range(0, 65535)));
      write_reg(pwbe_pkg::CFG_SHORT_WIDTH, pick_width());
      end_writes();
      steady_flow <= (ph == 2);
      queue_random_frames(36);
      drain();
    end

    if (mismatch_count == 0 && owed_symbols.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
